// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the sink request block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdsnk_pkg.sv =====
// Package with types and constants of the USB PD sink request block.
`default_nettype none

package pdsnk_pkg;

    localparam int unsigned MAX_OBJECTS_DEF = 7;

    // Input word kinds carried on tuser.
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_HEADER  = 2'd1;
    localparam logic [1:0] REQ_OBJECT  = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    // Result kinds carried on tuser.
    localparam logic [1:0] RES_REQUEST  = 2'd0;
    localparam logic [1:0] RES_CONTRACT = 2'd1;
    localparam logic [1:0] RES_GAVE_UP  = 2'd2;

    // Message types.
    localparam logic [4:0] MT_SOURCE_CAPS = 5'd1;
    localparam logic [4:0] MT_REQUEST     = 5'd2;
    localparam logic [4:0] MT_ACCEPT      = 5'd3;
    localparam logic [4:0] MT_REJECT      = 5'd4;
    localparam logic [4:0] MT_PS_RDY      = 5'd6;

    localparam logic [2:0] PD_REV_2_0 = 3'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACCEPT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_READY_TIMEOUT  = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd2;

    localparam logic [9:0] ACCEPT_TIMEOUT_RST = 10'd115;
    localparam logic [9:0] READY_TIMEOUT_RST  = 10'd650;
    localparam logic [2:0] RETRY_LIMIT_RST    = 3'd5;

    localparam logic [9:0] ELAPSED_MAX = 10'd1023;
    localparam logic [2:0] ERRORS_MAX  = 3'd7;

    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 72;

    typedef enum logic [4:0] {
        PH_WAIT_CAPS   = 5'b00001,
        PH_WAIT_ACCEPT = 5'b00010,
        PH_WAIT_READY  = 5'b00100,
        PH_DONE        = 5'b01000,
        PH_GAVE_UP     = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

// ===== rtl/usb_pd_sink_fixed_pdo_request_top.sv =====
// USB PD sink policy: picks the best fixed PDO, sends the request, tracks the contract.
// Latency: a result word is presented on the cycle after the input word that causes it.
// Throughput: one input word per cycle, stalled while a pending result is not taken.
// Per word: one 10x9 product and a 19-bit compare feed the state and result registers.
// Reset (synchronous, active low): waiting for capabilities, all counters and choices zero.
// Configuration registers return to 115 ms, 650 ms and five retries.
`default_nettype none

`include "assert_macros.svh"

module usb_pd_sink_fixed_pdo_request_top #(
    parameter int unsigned MAX_OBJECTS = pdsnk_pkg::MAX_OBJECTS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [1:0]                        i_cfg_index,
    input  wire  [9:0]                        i_cfg_data,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: rx_header[15:0], rx_object[47:16].
    input  wire  [pdsnk_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // Fields from bit 0: req_type[1:0].
    input  wire  [1:0]                        s_axis_tuser,
    input  wire                               s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // Fields from bit 0: tx_header[15:0], tx_object[47:16], contract_voltage_code[57:48],
    // contract_current_code[66:58], errors_seen[69:67], zero[71:70].
    output logic [pdsnk_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0: result_kind[1:0].
    output logic [1:0]                        m_axis_tuser
);
    import pdsnk_pkg::*;

    localparam logic [2:0] MaxPos = 3'(MAX_OBJECTS);

    logic [9:0]  r_accept_to;
    logic [9:0]  r_ready_to;
    logic [2:0]  r_retry_limit;

    t_phase      r_phase,    n_phase;
    logic [2:0]  r_err,      n_err;
    logic [2:0]  r_msg_id,   n_msg_id;
    logic [9:0]  r_elapsed,  n_elapsed;
    logic [4:0]  r_rx_type,  n_rx_type;
    logic [2:0]  r_pos,      n_pos;
    logic [18:0] r_bprod,    n_bprod;
    logic        r_bfound,   n_bfound;
    logic [2:0]  r_bpos,     n_bpos;
    logic [9:0]  r_cv,       n_cv;
    logic [8:0]  r_cc,       n_cc;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;
    logic [1:0]             r_out_user;

    logic        n_load;
    logic [1:0]  n_kind;
    logic [15:0] n_hdr;
    logic [31:0] n_obj;

    logic        w_accept;
    logic [1:0]  w_type;
    logic [15:0] w_rx_header;
    logic [31:0] w_rx_object;
    logic [9:0]  w_volt;
    logic [8:0]  w_curr;
    logic [18:0] w_prod;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_type        = s_axis_tuser;
    assign w_rx_header   = s_axis_tdata[15:0];
    assign w_rx_object   = s_axis_tdata[47:16];
    assign w_volt        = w_rx_object[19:10];
    assign w_curr        = w_rx_object[8:0];
    assign w_prod        = 19'(w_volt * w_curr);

    always_comb begin
        logic       v_complete;
        logic       v_error;
        logic [9:0] v_limit;
        logic [2:0] v_pos_inc;
        v_complete = 1'b0;
        v_error    = 1'b0;
        v_limit    = r_accept_to;
        v_pos_inc  = r_pos + 3'd1;
        n_phase    = r_phase;
        n_err      = r_err;
        n_msg_id   = r_msg_id;
        n_elapsed  = r_elapsed;
        n_rx_type  = r_rx_type;
        n_pos      = r_pos;
        n_bprod    = r_bprod;
        n_bfound   = r_bfound;
        n_bpos     = r_bpos;
        n_cv       = r_cv;
        n_cc       = r_cc;
        n_load     = 1'b0;
        n_kind     = RES_REQUEST;
        n_hdr      = '0;
        n_obj      = '0;

        if (w_type == REQ_RESTART) begin
            n_phase   = PH_WAIT_CAPS;
            n_err     = '0;
            n_elapsed = '0;
            n_pos     = MaxPos;
            n_bprod   = '0;
            n_bfound  = 1'b0;
            n_bpos    = '0;
        end else if (r_phase != PH_GAVE_UP) begin
            case (w_type)
                REQ_TICK: begin
                    if (r_phase == PH_WAIT_ACCEPT || r_phase == PH_WAIT_READY) begin
                        v_limit = (r_phase == PH_WAIT_READY) ? r_ready_to : r_accept_to;
                        if (r_elapsed != ELAPSED_MAX) begin
                            n_elapsed = r_elapsed + 10'd1;
                        end
                        v_error = (n_elapsed >= v_limit);
                    end
                end
                REQ_HEADER: begin
                    n_rx_type  = w_rx_header[4:0];
                    n_pos      = '0;
                    n_bprod    = '0;
                    n_bfound   = 1'b0;
                    n_bpos     = '0;
                    v_complete = s_axis_tlast;
                end
                default: begin
                    if (r_pos < MaxPos) begin
                        if (w_rx_object[31:30] == 2'b00 && w_prod >= r_bprod) begin
                            n_bprod  = w_prod;
                            n_bpos   = r_pos;
                            n_bfound = 1'b1;
                            if (r_rx_type == MT_SOURCE_CAPS &&
                                (r_phase == PH_WAIT_CAPS || r_phase == PH_DONE)) begin
                                n_cv = w_volt;
                                n_cc = w_curr;
                            end
                        end
                        n_pos      = v_pos_inc;
                        v_complete = s_axis_tlast || (v_pos_inc >= MaxPos);
                    end
                end
            endcase

            if (v_complete) begin
                n_pos = MaxPos;
                case (r_phase)
                    PH_WAIT_CAPS, PH_DONE: begin
                        if (n_rx_type == MT_SOURCE_CAPS && n_bfound) begin
                            n_load    = 1'b1;
                            n_kind    = RES_REQUEST;
                            n_hdr     = {4'b0, r_msg_id, PD_REV_2_0, 1'b0, MT_REQUEST};
                            n_obj     = {({1'b0, n_bpos} + 4'd1), 2'b00, 2'b11, 5'b0,
                                         n_cc, 1'b0, n_cc};
                            n_msg_id  = r_msg_id + 3'd1;
                            n_elapsed = '0;
                            n_phase   = PH_WAIT_ACCEPT;
                        end
                    end
                    PH_WAIT_ACCEPT: begin
                        if (n_rx_type == MT_ACCEPT) begin
                            n_elapsed = '0;
                            n_phase   = PH_WAIT_READY;
                        end else if (n_rx_type == MT_REJECT) begin
                            v_error = 1'b1;
                        end
                    end
                    PH_WAIT_READY: begin
                        if (n_rx_type == MT_PS_RDY) begin
                            n_phase = PH_DONE;
                            n_load  = 1'b1;
                            n_kind  = RES_CONTRACT;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (v_error) begin
                if (r_err != ERRORS_MAX) begin
                    n_err = r_err + 3'd1;
                end
                n_elapsed = '0;
                if (n_err > r_retry_limit) begin
                    n_phase = PH_GAVE_UP;
                    n_load  = 1'b1;
                    n_kind  = RES_GAVE_UP;
                end else begin
                    n_phase = PH_WAIT_CAPS;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_to   <= ACCEPT_TIMEOUT_RST;
            r_ready_to    <= READY_TIMEOUT_RST;
            r_retry_limit <= RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACCEPT_TIMEOUT: r_accept_to   <= i_cfg_data;
                CFG_READY_TIMEOUT:  r_ready_to    <= i_cfg_data;
                CFG_RETRY_LIMIT:    r_retry_limit <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT_CAPS;
            r_err     <= '0;
            r_msg_id  <= '0;
            r_elapsed <= '0;
            r_rx_type <= '0;
            r_pos     <= '0;
            r_bprod   <= '0;
            r_bfound  <= 1'b0;
            r_bpos    <= '0;
            r_cv      <= '0;
            r_cc      <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_err     <= n_err;
            r_msg_id  <= n_msg_id;
            r_elapsed <= n_elapsed;
            r_rx_type <= n_rx_type;
            r_pos     <= n_pos;
            r_bprod   <= n_bprod;
            r_bfound  <= n_bfound;
            r_bpos    <= n_bpos;
            r_cv      <= n_cv;
            r_cc      <= n_cc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && n_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_load) begin
            r_out_data <= {2'b00, n_err, n_cc, n_cv, n_obj, n_hdr};
            r_out_user <= n_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `AST_NEXT(a_req_arms, i_clk, i_rst_n, w_accept && n_load && n_kind == RES_REQUEST, r_phase == PH_WAIT_ACCEPT && r_elapsed == 10'd0, "request must arm the accept wait")
    `AST_NEXT(a_msg_id_step, i_clk, i_rst_n, w_accept && n_load && n_kind == RES_REQUEST, r_msg_id == 3'($past(r_msg_id) + 3'd1), "message id must advance after a request")
    `AST_IMPLY(a_gave_up_quiet, i_clk, i_rst_n, w_accept && r_phase == PH_GAVE_UP && w_type != REQ_RESTART, !n_load, "no result may follow giving up")
    `AST_NEXT(a_restart_clears, i_clk, i_rst_n, w_accept && w_type == REQ_RESTART, r_phase == PH_WAIT_CAPS && r_err == 3'd0 && !r_bfound, "restart must clear the negotiation")
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !m_axis_tready, r_out_valid && $stable(r_out_data), "pending result word must hold")

endmodule

`default_nettype wire
